>>> src/tpt_pkg.sv
package tpt_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned WidthW = 24;
  localparam int unsigned AddrW  = 2;
  localparam logic [WidthW-1:0] WidthReset = 24'd65536;
  localparam logic [AddrW-1:0] RegLineWidth = 2'd0;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StNorm  = 7'b0000010,
    StSqrt  = 7'b0000100,
    StDivB  = 7'b0001000,
    StDivA  = 7'b0010000,
    StEdges = 7'b0100000,
    StEmit  = 7'b1000000
  } state_e;

  function automatic logic [CoordW-1:0] sat_add(input logic signed [CoordW-1:0] p,
                                                input logic signed [CoordW:0] n,
                                                input logic neg);
    logic signed [CoordW+1:0] s;
    s = neg ? ($signed({{2{p[CoordW-1]}}, p}) - $signed({n[CoordW], n}))
            : ($signed({{2{p[CoordW-1]}}, p}) + $signed({n[CoordW], n}));
    if (s > $signed(34'sh07fffffff)) sat_add = 32'h7fffffff;
    else if (s < -$signed(34'sh080000000)) sat_add = 32'h80000000;
    else sat_add = s[CoordW-1:0];
  endfunction

endpackage

>>> src/tpt_if.sv
interface tpt_point_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic        start_of_line;
  modport source (output valid, point_x, point_y, start_of_line, input ready);
  modport sink (input valid, point_x, point_y, start_of_line, output ready);
endinterface

interface tpt_vertex_if;
  logic        valid;
  logic        ready;
  logic [31:0] vertex_x;
  logic [31:0] vertex_depth;
  logic        last_of_run;
  modport source (output valid, vertex_x, vertex_depth, last_of_run, input ready);
  modport sink (input valid, vertex_x, vertex_depth, last_of_run, output ready);
endinterface

>>> src/thick_polyline_tessellator_core.sv
// A joined point is normalized before its vertices show (more prescale shifts for short segments);
// a zero-length segment skips the math; start points emit none. A new point is taken only in idle,
// after the last vertex of the previous point is loaded. One shared multiplier and subtractor run
// the squares, a 32-step square root and two 24-step divisions. Six vertices then leave one per
// cycle, while the vertex sink is ready, from an output register.
// Reset (rst_ni low, asynchronous): line_width = 1.0, no point held, no vertex pending.
module thick_polyline_tessellator_core
  import tpt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  tpt_point_if.sink        pt,
  tpt_vertex_if.source     vx
);

  logic [WidthW-1:0] width_q;
  state_e state_q;
  logic signed [31:0] px_q, py_q, cx_q, cy_q;
  logic [31:0] lx_q, ld_q, rx_q, rd_q, nlx_q, nld_q, nrx_q, nrd_q;
  logic seen_q, edges_q;
  logic [32:0] a_q, b_q;     // |dx|, |dy|, then prescaled until the larger lies in [2^30, 2^31)
  logic dx_neg_q, dy_pos_q;
  logic [63:0] acc_q;        // radicand, then low dividend bits, consumed from the top
  logic [33:0] rem_q;        // partial remainder for sqrt and divide
  logic [31:0] root_q;
  logic [23:0] quo_q;
  logic [23:0] mb_q, ma_q;
  logic [4:0] cnt_q;
  logic [2:0] vi_q;
  logic ov_q;
  logic [31:0] ox_q, od_q;
  logic ol_q;

  assign pready = 1'b1;
  assign prdata = (paddr == RegLineWidth) ? {8'd0, width_q} : 32'd0;
  assign pt.ready = (state_q == StIdle);
  assign vx.valid = ov_q;
  assign vx.vertex_x = ox_q;
  assign vx.vertex_depth = od_q;
  assign vx.last_of_run = ol_q;

  logic signed [32:0] dx, dy;
  assign dx = $signed({cx_q[31], cx_q}) - $signed({px_q[31], px_q});
  assign dy = $signed({cy_q[31], cy_q}) - $signed({py_q[31], py_q});

  logic [32:0] dx_abs, dy_abs;
  assign dx_abs = dx[32] ? $unsigned(-dx) : $unsigned(dx);
  assign dy_abs = dy[32] ? $unsigned(-dy) : $unsigned(dy);

  logic [32:0] m;
  assign m = (a_q > b_q) ? a_q : b_q;

  // shared multiplier: a*a, b*b, then b*width and a*width
  logic use_b;
  logic [31:0] mul_x, mul_y;
  logic [63:0] prod, dvd;
  assign use_b = (state_q == StDivB) || (state_q == StNorm && cnt_q == 5'd3);
  assign mul_x = use_b ? b_q[31:0] : a_q[31:0];
  assign mul_y = (state_q == StNorm) ? mul_x : {8'd0, width_q};
  assign prod = {32'd0, mul_x} * {32'd0, mul_y};
  assign dvd = prod + {32'd0, root_q};

  // shared restoring step: sqrt and division use the same subtractor
  logic sq_mode;
  logic [35:0] sub_a, sub_b;
  logic [36:0] diff;
  logic [23:0] quo_next;
  assign sq_mode = (state_q == StSqrt);
  assign sub_a = sq_mode ? {rem_q, acc_q[63:62]} : {2'd0, rem_q[32:0], acc_q[63]};
  assign sub_b = sq_mode ? {2'd0, root_q, 2'b01} : {3'd0, root_q, 1'b0};
  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign quo_next = {quo_q[22:0], !diff[36]};

  logic signed [32:0] nx_s, ny_s;
  assign nx_s = dy_pos_q ? -$signed({9'd0, mb_q}) : $signed({9'd0, mb_q});
  assign ny_s = dx_neg_q ? -$signed({9'd0, ma_q}) : $signed({9'd0, ma_q});

  logic load_v;
  assign load_v = (state_q == StEmit) && (!ov_q || vx.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
      state_q <= StIdle;
      seen_q <= 1'b0;
      edges_q <= 1'b0;
      ov_q <= 1'b0;
      px_q <= '0;
      py_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
      lx_q <= '0;
      ld_q <= '0;
      rx_q <= '0;
      rd_q <= '0;
      nlx_q <= '0;
      nld_q <= '0;
      nrx_q <= '0;
      nrd_q <= '0;
      a_q <= '0;
      b_q <= '0;
      dx_neg_q <= 1'b0;
      dy_pos_q <= 1'b0;
      acc_q <= '0;
      rem_q <= '0;
      root_q <= '0;
      quo_q <= '0;
      mb_q <= '0;
      ma_q <= '0;
      cnt_q <= '0;
      vi_q <= '0;
      ox_q <= '0;
      od_q <= '0;
      ol_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == RegLineWidth) begin
        width_q <= pwdata[WidthW-1:0];
      end
      if (load_v) begin
        ov_q <= 1'b1;
      end else if (vx.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q) inside
        StIdle: begin
          if (pt.valid) begin
            cx_q <= pt.point_x;
            cy_q <= pt.point_y;
            if (pt.start_of_line || !seen_q) begin
              px_q <= pt.point_x;
              py_q <= pt.point_y;
              seen_q <= 1'b1;
              edges_q <= 1'b0;
            end else begin
              state_q <= StNorm;
              cnt_q <= '0;
            end
          end
        end
        StNorm: begin
          if (cnt_q == 5'd0) begin
            a_q <= dx_abs;
            b_q <= dy_abs;
            dx_neg_q <= dx[32];
            dy_pos_q <= !dy[32] && (dy != '0);
            if (dx == '0 && dy == '0) begin
              mb_q <= '0;
              ma_q <= '0;
              state_q <= StEdges;
            end else begin
              cnt_q <= 5'd1;
            end
          end else if (cnt_q == 5'd1) begin
            if (m[32] || m[31]) begin
              a_q <= a_q >> 1;
              b_q <= b_q >> 1;
            end else if (!m[30]) begin
              a_q <= a_q << 1;
              b_q <= b_q << 1;
            end else begin
              cnt_q <= 5'd2;
            end
          end else if (cnt_q == 5'd2) begin
            acc_q <= prod;
            cnt_q <= 5'd3;
          end else begin
            acc_q <= acc_q + prod;
            rem_q <= '0;
            root_q <= '0;
            cnt_q <= '0;
            state_q <= StSqrt;
          end
        end
        StSqrt: begin
          if (!diff[36]) begin
            rem_q <= diff[33:0];
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            rem_q <= sub_a[33:0];
            root_q <= {root_q[30:0], 1'b0};
          end
          acc_q <= {acc_q[61:0], 2'b00};
          if (cnt_q == 5'd31) begin
            cnt_q <= '0;
            state_q <= StDivB;
          end else cnt_q <= cnt_q + 5'd1;
        end
        StDivB, StDivA: begin
          if (cnt_q == 5'd0) begin
            // quotient fits 24 bits, so the top of the dividend is already below 2*len
            rem_q <= {2'd0, dvd[55:24]};
            acc_q <= {dvd[23:0], 40'd0};
            quo_q <= '0;
            cnt_q <= 5'd1;
          end else begin
            rem_q <= diff[36] ? sub_a[33:0] : diff[33:0];
            quo_q <= quo_next;
            acc_q <= {acc_q[62:0], 1'b0};
            if (cnt_q == 5'd24) begin
              cnt_q <= '0;
              if (state_q == StDivB) begin
                mb_q <= quo_next;
                state_q <= StDivA;
              end else begin
                ma_q <= quo_next;
                state_q <= StEdges;
              end
            end else cnt_q <= cnt_q + 5'd1;
          end
        end
        StEdges: begin
          if (!edges_q) begin
            lx_q <= sat_add(px_q, nx_s, 1'b0);
            ld_q <= sat_add(py_q, ny_s, 1'b0);
            rx_q <= sat_add(px_q, nx_s, 1'b1);
            rd_q <= sat_add(py_q, ny_s, 1'b1);
          end
          nlx_q <= sat_add(cx_q, nx_s, 1'b0);
          nld_q <= sat_add(cy_q, ny_s, 1'b0);
          nrx_q <= sat_add(cx_q, nx_s, 1'b1);
          nrd_q <= sat_add(cy_q, ny_s, 1'b1);
          vi_q <= '0;
          state_q <= StEmit;
        end
        StEmit: begin
          if (load_v) begin
            ol_q <= (vi_q == 3'd5);
            case (vi_q) inside
              3'd0, 3'd3: begin ox_q <= lx_q; od_q <= ld_q; end
              3'd1: begin ox_q <= rx_q; od_q <= rd_q; end
              3'd4: begin ox_q <= nlx_q; od_q <= nld_q; end
              default: begin ox_q <= nrx_q; od_q <= nrd_q; end
            endcase
            if (vi_q == 3'd5) begin
              lx_q <= nlx_q; ld_q <= nld_q; rx_q <= nrx_q; rd_q <= nrd_q;
              px_q <= cx_q; py_q <= cy_q;
              edges_q <= 1'b1;
              state_q <= StIdle;
            end
            vi_q <= vi_q + 3'd1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !vx.ready) |=> ($stable(ox_q) && ov_q)) else $error("vertex dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !pt.ready) else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEdges) |=> (state_q == StEmit)) else $error("edge step skipped");

endmodule
